### hw/rtl/oer_pkg.sv
// ----------------------------------------------------------------------------
// oer_pkg
// Shared types and constants for the OER tag encoder.
// ----------------------------------------------------------------------------
package oer_pkg;

   localparam int unsigned ClassWidth  = 2;
   localparam int unsigned NumberWidth = 32;
   localparam int unsigned OctetWidth  = 8;
   localparam int unsigned GroupBits   = 7;
   localparam int unsigned GroupCntW   = 3;

   // tag numbers below this fit in the head octet
   localparam logic [5:0] ShortLimit = 6'h3F;
   localparam logic [5:0] LongMark   = 6'h3F;

   typedef struct packed {
      logic [ClassWidth-1:0]  tag_class;
      logic [NumberWidth-1:0] tag_number;
   } req_type;

   typedef struct packed {
      logic [OctetWidth-1:0] out_byte;
      logic                  last;
   } rsp_type;

   // one tag held for emission; groups is zero for the short form
   typedef struct packed {
      logic [ClassWidth-1:0]  tag_class;
      logic [NumberWidth-1:0] tag_number;
      logic [GroupCntW-1:0]   groups;
   } item_type;

   // emission position within the held tag
   typedef struct packed {
      logic                 head;
      logic [GroupCntW-1:0] grp;
   } pos_type;

endpackage

### hw/rtl/oer_tag_encoder.sv
// ----------------------------------------------------------------------------
// oer_tag_encoder
// Turns an ASN.1 tag class and number into OER tag octets, one per cycle.
// ----------------------------------------------------------------------------
// channel   ports                         direction  handshake
// request   start, busy, req_data         in         start && !busy
// response  rsp_strobe, rsp_data          out        rsp_strobe per octet
//
// A tag goes out one octet per cycle: one octet for the short form, two to
// six for the long form, set by the single octet selector feeding the output
// register. A new tag is taken in the cycle its predecessor's final octet is
// selected, so short-form tags stream at one per cycle. Octets appear in the
// cycle after selection. Synchronous reset clears the active flag and strobe,
// not the held tag. The receiver cannot stall; busy is the only back-pressure.
// ----------------------------------------------------------------------------
module oer_tag_encoder import oer_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   item_type new_item;
   item_type item_ff, item_in;
   logic     act_ff, act_in;
   pos_type  pos_ff, pos_in;
   rsp_type  cur_rsp;
   rsp_type  rsp_ff;
   logic     strobe_ff;
   logic     accept;

   oer_group_count u_count (
      .req  (req_data),
      .item (new_item)
   );

   oer_octet_mux u_mux (
      .item (item_ff),
      .pos  (pos_ff),
      .rsp  (cur_rsp)
   );

   assign busy   = act_ff && !cur_rsp.last;
   assign accept = start && !busy;

   always_comb begin
      item_in = item_ff;
      act_in  = act_ff;
      pos_in  = pos_ff;
      if (accept) begin
         item_in    = new_item;
         act_in     = 1'b1;
         pos_in.head = 1'b1;
         pos_in.grp  = new_item.groups;
      end else if (act_ff && cur_rsp.last) begin
         act_in = 1'b0;
      end else if (act_ff) begin
         if (pos_ff.head) begin
            pos_in.head = 1'b0;
         end else begin
            pos_in.grp = pos_ff.grp - 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         act_ff    <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         act_ff    <= act_in;
         strobe_ff <= act_ff;
      end
      item_ff <= item_in;
      pos_ff  <= pos_in;
      rsp_ff  <= cur_rsp;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

### hw/rtl/oer_group_count.sv
// ----------------------------------------------------------------------------
// oer_group_count
// Works out how many base-128 groups follow the head octet of a tag.
// ----------------------------------------------------------------------------
module oer_group_count import oer_pkg::*; (
   input  req_type  req,
   output item_type item
);

   logic [NumberWidth-1:0] num;
   logic [GroupCntW-1:0]   groups;

   assign num = req.tag_number;

   always_comb begin
      if (num < {{(NumberWidth-6){1'b0}}, ShortLimit}) begin
         groups = 3'd0;
      end else if (num[31:28] != 4'd0) begin
         groups = 3'd5;
      end else if (num[27:21] != 7'd0) begin
         groups = 3'd4;
      end else if (num[20:14] != 7'd0) begin
         groups = 3'd3;
      end else if (num[13:7] != 7'd0) begin
         groups = 3'd2;
      end else begin
         groups = 3'd1;
      end
   end

   assign item.tag_class  = req.tag_class;
   assign item.tag_number = num;
   assign item.groups     = groups;

endmodule

### hw/rtl/oer_octet_mux.sv
// ----------------------------------------------------------------------------
// oer_octet_mux
// Picks the octet to send for the held tag at the current position.
// ----------------------------------------------------------------------------
module oer_octet_mux import oer_pkg::*; (
   input  item_type item,
   input  pos_type  pos,
   output rsp_type  rsp
);

   logic [GroupBits-1:0] grp_bits;
   logic                 grp_last;

   always_comb begin
      unique case (pos.grp)
         3'd5:    grp_bits = {3'd0, item.tag_number[31:28]};
         3'd4:    grp_bits = item.tag_number[27:21];
         3'd3:    grp_bits = item.tag_number[20:14];
         3'd2:    grp_bits = item.tag_number[13:7];
         3'd1:    grp_bits = item.tag_number[6:0];
         default: grp_bits = '0;
      endcase
   end

   assign grp_last = (pos.grp == 3'd1);

   always_comb begin
      if (pos.head) begin
         rsp.last = (item.groups == 3'd0);
         if (item.groups == 3'd0) begin
            rsp.out_byte = {item.tag_class, item.tag_number[5:0]};
         end else begin
            rsp.out_byte = {item.tag_class, LongMark};
         end
      end else begin
         rsp.last     = grp_last;
         rsp.out_byte = {~grp_last, grp_bits};
      end
   end

endmodule

### bench/oer_tag_encoder_test.sv
// ----------------------------------------------------------------------------
// oer_tag_encoder_test
// Self-checking bench for the OER tag encoder: tags go in through the
// start/busy port, and every octet that comes back is checked against the
// octet list predicted for each accepted tag, in order.
// ----------------------------------------------------------------------------
module oer_tag_encoder_test;
   import oer_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] ClassUniversal   = 2'd0;
   localparam logic [1:0] ClassApplication = 2'd1;
   localparam logic [1:0] ClassContext     = 2'd2;
   localparam logic [1:0] ClassPrivate     = 2'd3;

   localparam int RandomTags = 440;
   localparam int CycleLimit = 200000;
   localparam int DrainCycles = 10;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   req_type tags_pending[$];
   rsp_type octets_due[$];
   logic [31:0] edge_numbers[12];

   int   total_tags = 0;
   int   tags_sent = 0;
   int   tags_taken = 0;
   int   octets_seen = 0;
   int   short_tags = 0;
   int   long_tags = 0;
   int   six_octet_tags = 0;
   int   errors = 0;
   int   cycle = 0;
   int   phase1_end = 0;
   int   phase2_end = 0;
   logic taken = 1'b0;

   oer_tag_encoder dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #5 clock = ~clock;

   // expected octet list of one tag, in transmission order
   task automatic predict_tag_octets(input req_type tag);
      rsp_type     oct;
      logic [31:0] rest;
      int          groups;
      begin
         if (tag.tag_number < 32'd63) begin
            oct.out_byte = {tag.tag_class, tag.tag_number[5:0]};
            oct.last     = 1'b1;
            octets_due.push_back(oct);
            short_tags++;
         end else begin
            oct.out_byte = {tag.tag_class, LongMark};
            oct.last     = 1'b0;
            octets_due.push_back(oct);
            groups = 0;
            rest   = tag.tag_number;
            while (rest != 0) begin
               rest = rest >> GroupBits;
               groups++;
            end
            for (int k = groups; k > 0; k--) begin
               rest         = tag.tag_number >> ((k - 1) * GroupBits);
               oct.last     = (k == 1);
               oct.out_byte = {~oct.last, rest[6:0]};
               octets_due.push_back(oct);
            end
            long_tags++;
            if (groups == 5)
               six_octet_tags++;
         end
      end
   endtask

   task automatic note_mismatch(input string field, input logic [7:0] got,
                                input logic [7:0] want);
      begin
         $display("mismatch in %s at cycle %0d: got %h, expected %h",
                  field, cycle, got, want);
         errors++;
      end
   endtask

   function automatic req_type make_tag(input logic [1:0] cls, input logic [31:0] num);
      req_type t;
      begin
         t.tag_class  = cls;
         t.tag_number = num;
         return t;
      end
   endfunction

   // driver: a new word goes out once the previous one was taken
   always @(negedge clock) begin
      int idle_pct;
      idle_pct = (tags_sent < phase1_end) ? 26 : (tags_sent < phase2_end) ? 50 : 0;
      if (!reset && (!start || taken)) begin
         if (tags_pending.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
            req_data <= tags_pending.pop_front();
            start    <= 1'b1;
            tags_sent++;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: check octets first, then log the word accepted at this edge
   always @(posedge clock) begin
      rsp_type want;
      cycle++;
      if (rsp_strobe === 1'b1) begin
         octets_seen++;
         if (octets_due.size() == 0) begin
            note_mismatch("octet with nothing expected", rsp_data.out_byte, 8'h00);
         end else begin
            want = octets_due.pop_front();
            if (rsp_data.out_byte !== want.out_byte)
               note_mismatch("out_byte", rsp_data.out_byte, want.out_byte);
            if (rsp_data.last !== want.last)
               note_mismatch("last", {7'd0, rsp_data.last}, {7'd0, want.last});
         end
      end
      taken <= start && !busy;
      if (start && !busy) begin
         predict_tag_octets(req_data);
         tags_taken++;
      end
      if (cycle > CycleLimit) begin
         $display("timeout after %0d cycles, %0d of %0d tags taken",
                  cycle, tags_taken, total_tags);
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      logic [31:0] num;
      int          kind;
      int          width;

      edge_numbers = '{32'd62, 32'd63, 32'd64, 32'd127, 32'd128, 32'd16383,
                       32'd16384, 32'd2097151, 32'd2097152, 32'd268435455,
                       32'd268435456, 32'hFFFF_FFFF};

      // directed: every class, short/long boundary, each group count edge
      tags_pending.push_back(make_tag(ClassUniversal, 32'd0));
      tags_pending.push_back(make_tag(ClassApplication, 32'd1));
      tags_pending.push_back(make_tag(ClassContext, 32'd62));
      tags_pending.push_back(make_tag(ClassPrivate, 32'd62));
      // exactly 63 takes the long form with a single group
      tags_pending.push_back(make_tag(ClassUniversal, 32'd63));
      tags_pending.push_back(make_tag(ClassPrivate, 32'd63));
      tags_pending.push_back(make_tag(ClassApplication, 32'd64));
      tags_pending.push_back(make_tag(ClassContext, 32'd127));
      tags_pending.push_back(make_tag(ClassUniversal, 32'd128));
      tags_pending.push_back(make_tag(ClassApplication, 32'd16383));
      tags_pending.push_back(make_tag(ClassContext, 32'd16384));
      tags_pending.push_back(make_tag(ClassPrivate, 32'd2097151));
      tags_pending.push_back(make_tag(ClassUniversal, 32'd2097152));
      tags_pending.push_back(make_tag(ClassApplication, 32'd268435455));
      tags_pending.push_back(make_tag(ClassContext, 32'd268435456));
      tags_pending.push_back(make_tag(ClassPrivate, 32'hFFFF_FFFF));
      tags_pending.push_back(make_tag(ClassUniversal, 32'h8000_0000));
      tags_pending.push_back(make_tag(ClassApplication, 32'h5555_5555));
      tags_pending.push_back(make_tag(ClassContext, 32'hAAAA_AAAA));
      tags_pending.push_back(make_tag(ClassPrivate, 32'd0));

      for (int i = 0; i < RandomTags; i++) begin
         kind = $urandom_range(9, 0);
         if (kind < 4) begin
            num = $urandom_range(62, 0);
         end else if (kind < 6) begin
            num = edge_numbers[$urandom_range(11, 0)];
         end else begin
            // random bit length spreads tags over all group counts
            width = $urandom_range(32, 1);
            num = $urandom;
            if (width < 32)
               num = num & ((32'd1 << width) - 32'd1);
         end
         tags_pending.push_back(make_tag(2'($urandom_range(3, 0)), num));
      end

      total_tags = tags_pending.size();
      phase1_end = total_tags / 3;
      phase2_end = 2 * total_tags / 3;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (tags_taken != total_tags || octets_due.size() != 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("covered %0d tags: %0d short form, %0d long form, %0d with six octets",
               tags_taken, short_tags, long_tags, six_octet_tags);
      $display("checked %0d octets in %0d cycles, %0d mismatches",
               octets_seen, cycle, errors);
      if (errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
